### sv/sac_pkg.sv
// sac_pkg: widths, constants and shared types for the swept box collision block
// depends on nothing
package sac_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TIME_FRAC_BITS = 16;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int GAP_W          = COORD_BITS + 2;
    localparam int NUM_W          = GAP_W + TIME_FRAC_BITS;
    localparam int DEN_W          = COORD_BITS;
    localparam int QB             = TIME_FRAC_BITS + 1;
    localparam int TIME_W         = TIME_FRAC_BITS + 2;
    localparam int CT_W           = TIME_FRAC_BITS + 1;
    localparam int DIV_LAT        = QB + 2;

    localparam logic signed [TIME_W-1:0] T_MINUS1 = '1;
    localparam logic signed [TIME_W-1:0] T_ONE    = TIME_W'(2 ** TIME_FRAC_BITS);
    localparam logic signed [TIME_W-1:0] T_OVER   = TIME_W'(2 ** TIME_FRAC_BITS + 1);
    localparam logic [CT_W-1:0]          CT_ONE   = CT_W'(2 ** TIME_FRAC_BITS);

    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;

    typedef struct packed {
        logic [NUM_W-1:0] nmag;
        logic [DEN_W-1:0] dmag;
        logic             neg;
    } div_req_t;

    typedef struct packed {
        logic zx;
        logic zy;
        logic sx;
        logic sy;
    } side_t;

    typedef struct packed {
        logic  valid;
        side_t side;
    } tag_t;

endpackage

### sv/sac_prep.sv
// sac_prep: edge gaps per axis, split into magnitude and sign for the dividers
// depends on sac_pkg
module sac_prep
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_width,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_height,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vel_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vel_y,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_width,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_height,
    output sac_pkg::div_req_t                     in_x,
    output sac_pkg::div_req_t                     out_x,
    output sac_pkg::div_req_t                     in_y,
    output sac_pkg::div_req_t                     out_y,
    output sac_pkg::side_t                        side
);

    localparam int GW = sac_pkg::GAP_W;
    localparam int TF = sac_pkg::TIME_FRAC_BITS;

    sac_pkg::div_req_t in_x_reg, out_x_reg, in_y_reg, out_y_reg;
    sac_pkg::div_req_t in_x_next, out_x_next, in_y_next, out_y_next;
    sac_pkg::side_t    side_reg, side_next;

    function automatic sac_pkg::div_req_t mk_req(logic signed [GW-1:0] gap,
                                                 logic signed [sac_pkg::COORD_BITS-1:0] vel);
        sac_pkg::div_req_t r;
        logic [GW-1:0] mag;
        mag    = gap[GW-1] ? GW'(-gap) : GW'(gap);
        r.nmag = {mag, {TF{1'b0}}};
        r.dmag = vel[sac_pkg::COORD_BITS-1] ? sac_pkg::DEN_W'(-vel) : sac_pkg::DEN_W'(vel);
        r.neg  = gap[GW-1] ^ vel[sac_pkg::COORD_BITS-1];
        return r;
    endfunction

    logic signed [GW-1:0] mnx, fnx, mny, fny, tnx, tfx, tny, tfy;
    logic signed [GW-1:0] gxi, gxo, gyi, gyo;
    logic                 px, py;

    always_comb
    begin
        mnx = GW'(mover_x);
        mny = GW'(mover_y);
        tnx = GW'(target_x);
        tny = GW'(target_y);
        fnx = mnx + GW'({1'b0, mover_width});
        fny = mny + GW'({1'b0, mover_height});
        tfx = tnx + GW'({1'b0, target_width});
        tfy = tny + GW'({1'b0, target_height});
        px  = !mover_vel_x[sac_pkg::COORD_BITS-1] && (mover_vel_x != '0);
        py  = !mover_vel_y[sac_pkg::COORD_BITS-1] && (mover_vel_y != '0);
        if (px)
        begin
            gxi = tnx - fnx;
            gxo = tfx - mnx;
        end
        else
        begin
            gxi = tfx - mnx;
            gxo = tnx - fnx;
        end
        if (py)
        begin
            gyi = tny - fny;
            gyo = tfy - mny;
        end
        else
        begin
            gyi = tfy - mny;
            gyo = tny - fny;
        end
        in_x_next  = mk_req(gxi, mover_vel_x);
        out_x_next = mk_req(gxo, mover_vel_x);
        in_y_next  = mk_req(gyi, mover_vel_y);
        out_y_next = mk_req(gyo, mover_vel_y);
        side_next.zx = (mover_vel_x == '0);
        side_next.zy = (mover_vel_y == '0);
        side_next.sx = gxi[GW-1];
        side_next.sy = gyi[GW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_x_reg  <= in_x_next;
            out_x_reg <= out_x_next;
            in_y_reg  <= in_y_next;
            out_y_reg <= out_y_next;
            side_reg  <= side_next;
        end
    end

    assign in_x  = in_x_reg;
    assign out_x = out_x_reg;
    assign in_y  = in_y_reg;
    assign out_y = out_y_reg;
    assign side  = side_reg;

endmodule

### sv/sac_div.sv
// sac_div: pipelined restoring divider, one quotient bit per stage, floor and clamp
// depends on sac_pkg
module sac_div
(
    input  logic                                clk,
    input  logic                                en,
    input  sac_pkg::div_req_t                   req,
    output logic signed [sac_pkg::TIME_W-1:0]   quot
);

    localparam int NW = sac_pkg::NUM_W;
    localparam int DW = sac_pkg::DEN_W;
    localparam int QB = sac_pkg::QB;

    logic [NW-1:0] r_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic signed [sac_pkg::TIME_W-1:0] quot_reg, quot_next;

    // overflow when the quotient needs more than QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= req.nmag;
            q_reg[0]   <= '0;
            d_reg[0]   <= req.dmag;
            neg_reg[0] <= req.neg;
            ovf_reg[0] <= req.nmag >= (NW'(req.dmag) << QB);
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        logic [NW:0]   dsh;
        logic [NW:0]   trial;
        logic [NW-1:0] r_next;
        logic          bit_next;

        always_comb
        begin
            dsh      = (NW+1)'(d_reg[s]) << (QB - 1 - s);
            trial    = {1'b0, r_reg[s]} - dsh;
            bit_next = !trial[NW];
            r_next   = bit_next ? trial[NW-1:0] : r_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]   <= r_next;
                q_reg[s+1]   <= {q_reg[s][QB-2:0], bit_next};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    // negative times all act alike downstream, as do times past one frame
    always_comb
    begin
        if (neg_reg[QB])
        begin
            if (ovf_reg[QB] || (q_reg[QB] != '0) || (r_reg[QB] != '0))
                quot_next = sac_pkg::T_MINUS1;
            else
                quot_next = '0;
        end
        else if (ovf_reg[QB] || (sac_pkg::TIME_W'(q_reg[QB]) > sac_pkg::T_OVER))
            quot_next = sac_pkg::T_OVER;
        else
            quot_next = sac_pkg::TIME_W'(q_reg[QB]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

### sv/sac_decide.sv
// sac_decide: entry and exit selection, hit test, normal choice, result register
// depends on sac_pkg
module sac_decide
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sac_pkg::TIME_W-1:0]   tin_x,
    input  logic signed [sac_pkg::TIME_W-1:0]   tout_x,
    input  logic signed [sac_pkg::TIME_W-1:0]   tin_y,
    input  logic signed [sac_pkg::TIME_W-1:0]   tout_y,
    input  sac_pkg::side_t                      side,
    output logic                                hit,
    output logic        [sac_pkg::CT_W-1:0]     contact_time,
    output logic signed [1:0]                   normal_x,
    output logic signed [1:0]                   normal_y
);

    localparam int TW = sac_pkg::TIME_W;

    logic signed [TW-1:0] ex, xx, ey, xy, entry, exit_t;
    logic                 x_wins, miss;
    logic                 hit_reg, hit_next;
    logic [sac_pkg::CT_W-1:0] ct_reg, ct_next;
    logic signed [1:0]    nx_reg, nx_next, ny_reg, ny_next;

    always_comb
    begin
        ex = side.zx ? sac_pkg::T_MINUS1 : tin_x;
        xx = side.zx ? sac_pkg::T_OVER   : tout_x;
        ey = side.zy ? sac_pkg::T_MINUS1 : tin_y;
        xy = side.zy ? sac_pkg::T_OVER   : tout_y;
        x_wins = ex > ey;
        entry  = x_wins ? ex : ey;
        exit_t = (xx < xy) ? xx : xy;
        miss = (entry > exit_t) || (ex[TW-1] && ey[TW-1])
            || (ex > sac_pkg::T_ONE) || (ey > sac_pkg::T_ONE);
        hit_next = !miss;
        nx_next  = sac_pkg::NRM_ZERO;
        ny_next  = sac_pkg::NRM_ZERO;
        if (miss)
            ct_next = sac_pkg::CT_ONE;
        else
        begin
            ct_next = entry[sac_pkg::CT_W-1:0];
            if (x_wins)
                nx_next = side.sx ? sac_pkg::NRM_POS : sac_pkg::NRM_NEG;
            else
                ny_next = side.sy ? sac_pkg::NRM_POS : sac_pkg::NRM_NEG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            ct_reg  <= ct_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
        end
    end

    assign hit          = hit_reg;
    assign contact_time = ct_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;

endmodule

### sv/swept_aabb_collision_time.sv
// swept_aabb_collision_time: top level, gap stage, four divider pipelines, decision stage
// depends on sac_pkg, sac_prep, sac_div, sac_decide
// One box pair enters per cycle while in_stall is low; its result passes one gap stage,
// 19 divider stages with 17 quotient bits one per stage, and one decision stage. The whole
// pipeline holds while a result waits under out_stall; in_stall follows that condition.
// Times are unsigned Q1.16 with 65536 meaning no hit; the normal is a -1/0/+1 pair.
module swept_aabb_collision_time
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_width,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  mover_height,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vel_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] mover_vel_y,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_x,
    input  logic signed [sac_pkg::COORD_BITS-1:0] target_y,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_width,
    input  logic        [sac_pkg::SIZE_BITS-1:0]  target_height,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic        [sac_pkg::CT_W-1:0]       contact_time,
    output logic signed [1:0]                     normal_x,
    output logic signed [1:0]                     normal_y
);

    localparam int LAT = sac_pkg::DIV_LAT;

    logic en;
    sac_pkg::div_req_t rq_in_x, rq_out_x, rq_in_y, rq_out_y;
    sac_pkg::side_t    side_p;
    logic signed [sac_pkg::TIME_W-1:0] t_in_x, t_out_x, t_in_y, t_out_y;
    logic              v_prep_reg;
    sac_pkg::tag_t     tag_reg [LAT];
    logic              v_out_reg;

    assign en       = !(v_out_reg && out_stall);
    assign in_stall = !en;

    sac_prep u_prep
    (
        .clk           (clk),
        .en            (en),
        .mover_x       (mover_x),
        .mover_y       (mover_y),
        .mover_width   (mover_width),
        .mover_height  (mover_height),
        .mover_vel_x   (mover_vel_x),
        .mover_vel_y   (mover_vel_y),
        .target_x      (target_x),
        .target_y      (target_y),
        .target_width  (target_width),
        .target_height (target_height),
        .in_x          (rq_in_x),
        .out_x         (rq_out_x),
        .in_y          (rq_in_y),
        .out_y         (rq_out_y),
        .side          (side_p)
    );

    sac_div u_div_in_x  (.clk(clk), .en(en), .req(rq_in_x),  .quot(t_in_x));
    sac_div u_div_out_x (.clk(clk), .en(en), .req(rq_out_x), .quot(t_out_x));
    sac_div u_div_in_y  (.clk(clk), .en(en), .req(rq_in_y),  .quot(t_in_y));
    sac_div u_div_out_y (.clk(clk), .en(en), .req(rq_out_y), .quot(t_out_y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prep_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else if (en)
        begin
            v_prep_reg <= in_valid;
            v_out_reg  <= tag_reg[LAT-1].valid;
        end
    end

    // valid and side info ride alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                tag_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_reg[0].valid <= v_prep_reg;
            tag_reg[0].side  <= side_p;
            for (int i = 1; i < LAT; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    sac_decide u_decide
    (
        .clk          (clk),
        .en           (en),
        .tin_x        (t_in_x),
        .tout_x       (t_out_x),
        .tin_y        (t_in_y),
        .tout_y       (t_out_y),
        .side         (tag_reg[LAT-1].side),
        .hit          (hit),
        .contact_time (contact_time),
        .normal_x     (normal_x),
        .normal_y     (normal_y)
    );

    assign out_valid = v_out_reg;

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for swept_aabb_collision_time
// depends on sac_pkg and the swept_aabb_collision_time rtl; directed table then random words
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic signed [15:0] mx, my, vx, vy, tx, ty;
        logic [14:0]        mw, mh, tw, th;
    } pair_t;

    typedef struct {
        logic                     hit;
        logic [sac_pkg::CT_W-1:0] ct;
        logic signed [1:0]        nx, ny;
    } contact_t;

    typedef struct {
        pair_t    p;
        bit       known;
        contact_t r;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_stall = 0;
    logic signed [15:0] mover_x = 0, mover_y = 0, mover_vel_x = 0, mover_vel_y = 0;
    logic signed [15:0] target_x = 0, target_y = 0;
    logic [14:0] mover_width = 0, mover_height = 0, target_width = 0, target_height = 0;
    logic in_stall, out_valid, hit;
    logic [sac_pkg::CT_W-1:0] contact_time;
    logic signed [1:0] normal_x, normal_y;

    contact_t contact_q[$];
    int errors = 0;
    int hold_cnt = 0;

    swept_aabb_collision_time DUT (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q -= 1;
        return q;
    endfunction

    function automatic contact_t sweep_contact(pair_t p);
        contact_t r;
        longint mx, my, vx, vy, tx, ty, mw, mh, tw, th;
        longint gxi, gxo, gyi, gyo, ex, xx, ey, xy, en, ext, one;
        one = longint'(1) << sac_pkg::TIME_FRAC_BITS;
        mx = longint'(p.mx); my = longint'(p.my); vx = longint'(p.vx); vy = longint'(p.vy);
        tx = longint'(p.tx); ty = longint'(p.ty);
        mw = longint'(p.mw); mh = longint'(p.mh); tw = longint'(p.tw); th = longint'(p.th);
        if (vx > 0)
        begin
            gxi = tx - (mx + mw); gxo = (tx + tw) - mx;
        end
        else
        begin
            gxi = (tx + tw) - mx; gxo = tx - (mx + mw);
        end
        if (vy > 0)
        begin
            gyi = ty - (my + mh); gyo = (ty + th) - my;
        end
        else
        begin
            gyi = (ty + th) - my; gyo = ty - (my + mh);
        end
        if (vx == 0)
        begin
            ex = 64'sh8000_0000_0000_0000; xx = 64'sh7fff_ffff_ffff_ffff;
        end
        else
        begin
            ex = floor_div(gxi * one, vx); xx = floor_div(gxo * one, vx);
        end
        if (vy == 0)
        begin
            ey = 64'sh8000_0000_0000_0000; xy = 64'sh7fff_ffff_ffff_ffff;
        end
        else
        begin
            ey = floor_div(gyi * one, vy); xy = floor_div(gyo * one, vy);
        end
        en = ex > ey ? ex : ey;
        ext = xx < xy ? xx : xy;
        r.nx = sac_pkg::NRM_ZERO;
        r.ny = sac_pkg::NRM_ZERO;
        if (en > ext || (ex < 0 && ey < 0) || ex > one || ey > one)
        begin
            r.hit = 0;
            r.ct = sac_pkg::CT_ONE;
        end
        else
        begin
            r.hit = 1;
            r.ct = sac_pkg::CT_W'(en);
            if (ex > ey)
                r.nx = gxi < 0 ? sac_pkg::NRM_POS : sac_pkg::NRM_NEG;
            else
                r.ny = gyi < 0 ? sac_pkg::NRM_POS : sac_pkg::NRM_NEG;
        end
        return r;
    endfunction

    function automatic pair_t mk(int mx, int my, int mw, int mh, int vx, int vy,
                                 int tx, int ty, int tw, int th);
        pair_t p;
        p.mx = 16'(mx); p.my = 16'(my); p.mw = 15'(mw); p.mh = 15'(mh);
        p.vx = 16'(vx); p.vy = 16'(vy);
        p.tx = 16'(tx); p.ty = 16'(ty); p.tw = 15'(tw); p.th = 15'(th);
        return p;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.mx = 16'($urandom); p.my = 16'($urandom); p.vx = 16'($urandom);
        p.vy = 16'($urandom); p.tx = 16'($urandom); p.ty = 16'($urandom);
        p.mw = 15'($urandom); p.mh = 15'($urandom); p.tw = 15'($urandom);
        p.th = 15'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            // near pairs so that hits are common
            p.mx = 16'($signed(16'($urandom_range(0, 1023))) - 512);
            p.my = 16'($signed(16'($urandom_range(0, 1023))) - 512);
            p.mw = 15'($urandom_range(0, 200)); p.mh = 15'($urandom_range(0, 200));
            p.tw = 15'($urandom_range(0, 200)); p.th = 15'($urandom_range(0, 200));
            p.tx = 16'(p.mx + $signed(16'($urandom_range(0, 1200))) - 600);
            p.ty = 16'(p.my + $signed(16'($urandom_range(0, 1200))) - 600);
            p.vx = 16'($signed(16'($urandom_range(0, 2000))) - 1000);
            p.vy = 16'($signed(16'($urandom_range(0, 2000))) - 1000);
            if ($urandom_range(0, 7) == 0) p.vx = '0;
            if ($urandom_range(0, 7) == 0) p.vy = '0;
        end
        return p;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task automatic send_word(pair_t p, bit known, contact_t r);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        mover_x <= p.mx; mover_y <= p.my; mover_width <= p.mw; mover_height <= p.mh;
        mover_vel_x <= p.vx; mover_vel_y <= p.vy; target_x <= p.tx; target_y <= p.ty;
        target_width <= p.tw; target_height <= p.th;
        in_valid <= 1;
        contact_q.push_back(known ? r : sweep_contact(p));
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // sample at the edge, before nonblocking updates land, so results never depend on event order
    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (contact_q.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                e = contact_q.pop_front();
                if (hit !== e.hit) report("hit", 32'(hit), 32'(e.hit));
                if (contact_time !== e.ct)
                    report("contact_time", 32'(contact_time), 32'(e.ct));
                if (normal_x !== e.nx) report("normal_x", 32'(normal_x), 32'(e.nx));
                if (normal_y !== e.ny) report("normal_y", 32'(normal_y), 32'(e.ny));
            end
        end
    end

    // receiver wait drawn per word taken
    always @(posedge clk)
    begin
        int n;
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= (hold_cnt > 1);
        end
        else if (out_valid && !out_stall)
        begin
            n = $urandom_range(0, 7);
            hold_cnt <= n;
            out_stall <= (n != 0);
        end
    end

    initial
    begin
        row_t dir[$];
        row_t row;
        contact_t miss;
        int waited;
        miss.hit = 0; miss.ct = sac_pkg::CT_ONE;
        miss.nx = sac_pkg::NRM_ZERO; miss.ny = sac_pkg::NRM_ZERO;
        // both velocities zero
        row.p = mk(0, 0, 16, 16, 0, 0, 0, 0, 16, 16); row.known = 1; row.r = miss;
        dir.push_back(row);
        row.p = mk(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767, 32767, 32767);
        dir.push_back(row);
        row.known = 0;
        row.p = mk(0, 0, 16, 16, 32, 0, 32, 0, 16, 16); dir.push_back(row);
        row.p = mk(64, 0, 16, 16, -32, 0, 32, 0, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 0, 32, 0, 32, 16, 16); dir.push_back(row);
        row.p = mk(0, 64, 16, 16, 0, -32, 0, 32, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 32, 32, 32, 32, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 16, 16, 16, 16, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 1, 1, 32767, 32767, 32767, 32767); dir.push_back(row);
        row.p = mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
        dir.push_back(row);
        row.p = mk(-32768, 32767, 0, 0, 32767, -32768, 32767, -32768, 0, 0); dir.push_back(row);
        row.p = mk(0, 0, 0, 0, -1, 32767, 0, 0, 0, 0); dir.push_back(row);
        row.p = mk(0, 0, 32767, 32767, 1, -1, 0, 0, 32767, 32767); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 7, 3, 100, 5, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, -7, 3, -100, 5, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 32, 0, 64, 100, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, 32, 32, 48, 48, 16, 16); dir.push_back(row);
        row.p = mk(0, 0, 16, 16, -32768, -32768, 32767, 32767, 0, 0); dir.push_back(row);

        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir[i]) send_word(dir[i].p, dir[i].known, dir[i].r);
        in_valid <= 0;
        // hold off until the pipeline has drained
        waited = 0;
        while (contact_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        for (int i = 0; i < 1600; i++)
            send_word(rand_pair(), 0, miss);
        in_valid <= 0;
        waited = 0;
        while (contact_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        if (contact_q.size() != 0)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
